FILE: hw/rtl/tpr_pkg.sv
// Package for the timer period to prescaler/reload calculator.
// Field widths and fixed constants shared by the top level; no dependencies.
package tpr_pkg;

  localparam int PERIOD_W  = 32;
  localparam int CLK_HZ_W  = 32;
  localparam int FIELD_W   = 16;
  localparam int PROD_W    = PERIOD_W + CLK_HZ_W;
  // (2^32-1)^2 / 10^6 < 2^45
  localparam int TICKS_W   = 45;
  localparam logic [CLK_HZ_W-1:0] CLK_HZ_RESET = 32'd32000000;

  // 10^6 = 2^6 * 15625: ticks = ((prod >> 6) * RECIP) >> RECIP_SHIFT,
  // exact for any 58-bit scaled product (RECIP * 15625 - 2^72 < 2^14)
  localparam int US_POW2_SHIFT = 6;
  localparam int SCALED_W      = PROD_W - US_POW2_SHIFT;
  localparam int RECIP_W       = 59;
  localparam int RECIP_SHIFT   = 72;
  // ceil(2^72 / 15625)
  localparam logic [RECIP_W-1:0] RECIP = 59'd302231454903657294;

  // 32-bit slices of the reciprocal multiply
  localparam int HALF_W   = 32;
  localparam int Y1_W     = SCALED_W - HALF_W;
  localparam int M1_W     = RECIP_W - HALF_W;
  localparam int P00_W    = 2 * HALF_W;
  localparam int P01_W    = HALF_W + M1_W;
  localparam int P10_W    = Y1_W + HALF_W;
  localparam int P11_W    = Y1_W + M1_W;
  localparam int LO_W     = HALF_W + 2;
  localparam int HI_W     = P11_W + 1;
  localparam int TICK_LSB = RECIP_SHIFT - P00_W;

endpackage

FILE: hw/rtl/tpr_pipe_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Generic over widths; carries a sideband word alongside each item. No package use.
module tpr_pipe_div #(
  parameter int DIVIDEND_W = 64,
  parameter int DIVISOR_W  = 20,
  parameter int QUOT_W     = 45,
  parameter int SIDE_W     = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  out_valid,
  output logic [QUOT_W-1:0]     quotient,
  output logic [SIDE_W-1:0]     side_out
);

  localparam int CMP_W = DIVIDEND_W + DIVISOR_W;

  // registered outputs of each stage; stage 0 reads the ports
  logic                  v_q    [1:QUOT_W];
  logic [DIVIDEND_W-1:0] rem_q  [1:QUOT_W-1];
  logic [DIVISOR_W-1:0]  dvs_q  [1:QUOT_W-1];
  logic [QUOT_W-1:0]     quo_q  [1:QUOT_W];
  logic [SIDE_W-1:0]     side_q [1:QUOT_W];

  genvar k;
  generate
    for (k = 0; k < QUOT_W; k++) begin : g_stage
      // stage k resolves quotient bit QUOT_W-1-k; quotient must fit QUOT_W bits
      localparam int B = QUOT_W - 1 - k;
      logic                  v_in;
      logic [DIVIDEND_W-1:0] rem_in;
      logic [DIVISOR_W-1:0]  dvs_in;
      logic [QUOT_W-1:0]     quo_in;
      logic [SIDE_W-1:0]     sd_in;
      logic [CMP_W-1:0]      trial;
      logic                  ge;

      if (k == 0) begin : g_first
        assign v_in   = in_valid;
        assign rem_in = dividend;
        assign dvs_in = divisor;
        assign quo_in = '0;
        assign sd_in  = side_in;
      end else begin : g_next
        assign v_in   = v_q[k];
        assign rem_in = rem_q[k];
        assign dvs_in = dvs_q[k];
        assign quo_in = quo_q[k];
        assign sd_in  = side_q[k];
      end

      assign trial = CMP_W'(dvs_in) << B;
      assign ge    = CMP_W'(rem_in) >= trial;

      always_ff @(posedge clk) begin
        if (rst) begin
          v_q[k+1] <= 1'b0;
        end else if (en) begin
          v_q[k+1] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          quo_q[k+1]  <= {quo_in[QUOT_W-2:0], ge};
          side_q[k+1] <= sd_in;
        end
      end

      if (k < QUOT_W - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (en) begin
            rem_q[k+1] <= ge ? (rem_in - trial[DIVIDEND_W-1:0]) : rem_in;
            dvs_q[k+1] <= dvs_in;
          end
        end
      end
    end
  endgenerate

  assign out_valid = v_q[QUOT_W];
  assign quotient  = quo_q[QUOT_W];
  assign side_out  = side_q[QUOT_W];

endmodule

FILE: hw/rtl/timer_period_to_prescaler_reload.sv
// Throughput: one item per cycle while not stalled; 32x32 multiply, three-stage
// reciprocal multiply for the divide by 10^6, prescaler stage, (COUNTER_BITS+1)-stage
// reload divide, output register with skid slot.
// Stalls hold the whole pipeline only while the skid slot is occupied.
// Reset (rst, synchronous): pipeline valids cleared, timer_clock_hz = 32000000.
// Depends on tpr_pkg and tpr_pipe_div.
module timer_period_to_prescaler_reload #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [tpr_pkg::CLK_HZ_W-1:0]   cfg_wdata,   // timer_clock_hz
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tpr_pkg::PERIOD_W-1:0]   s_tdata,     // [31:0] period
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [2*tpr_pkg::FIELD_W-1:0]  m_tdata,     // [15:0] prescaler, [31:16] reload
  output logic                           m_tuser      // [0] status
);

  import tpr_pkg::*;

  localparam int SUM_W  = TICKS_W + 1;
  localparam int PSC_W  = COUNTER_BITS + 1;
  localparam int RW     = (PSC_W > FIELD_W) ? PSC_W : FIELD_W;
  localparam int SIDE_W = FIELD_W + 1;

  logic [CLK_HZ_W-1:0] timer_clock_hz;
  logic                en;
  logic                skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_clock_hz <= CLK_HZ_RESET;
    end else if (cfg_wen) begin
      timer_clock_hz <= cfg_wdata;
    end
  end

  assign en       = ~skid_v;
  assign s_tready = en;

  // multiply stage
  logic              mul_v;
  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
    end else if (en) begin
      mul_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(timer_clock_hz) * PROD_W'(s_tdata);
    end
  end

  // ticks = prod / 10^6: partial products of (prod >> 6) and the reciprocal
  logic [SCALED_W-1:0] scaled;
  logic [P00_W-1:0]    p00_c;
  logic                pp_v;
  logic [HALF_W-1:0]   pp00_hi;
  logic [P01_W-1:0]    pp01;
  logic [P10_W-1:0]    pp10;
  logic [P11_W-1:0]    pp11;

  assign scaled = prod[PROD_W-1:US_POW2_SHIFT];
  assign p00_c  = P00_W'(scaled[HALF_W-1:0]) * P00_W'(RECIP[HALF_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_v <= 1'b0;
    end else if (en) begin
      pp_v <= mul_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_hi <= p00_c[P00_W-1:HALF_W];
      pp01    <= P01_W'(scaled[HALF_W-1:0]) * P01_W'(RECIP[RECIP_W-1:HALF_W]);
      pp10    <= P10_W'(scaled[SCALED_W-1:HALF_W]) * P10_W'(RECIP[HALF_W-1:0]);
      pp11    <= P11_W'(scaled[SCALED_W-1:HALF_W]) * P11_W'(RECIP[RECIP_W-1:HALF_W]);
    end
  end

  // bits 32..63 of the full product; only the carry out is kept
  logic [LO_W-1:0]  lo_sum;
  logic             lo_v;
  logic [1:0]       lo_c;
  logic [M1_W-1:0]  hi01;
  logic [Y1_W-1:0]  hi10;
  logic [P11_W-1:0] hi11;

  assign lo_sum = LO_W'(pp00_hi) + LO_W'(pp01[HALF_W-1:0]) + LO_W'(pp10[HALF_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_v <= 1'b0;
    end else if (en) begin
      lo_v <= pp_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_c <= lo_sum[LO_W-1:HALF_W];
      hi01 <= pp01[P01_W-1:HALF_W];
      hi10 <= pp10[P10_W-1:HALF_W];
      hi11 <= pp11;
    end
  end

  // upper part of the full product, ticks = that >> (RECIP_SHIFT - 64)
  logic [HI_W-1:0]    hi_sum;
  logic               d1_v;
  logic [TICKS_W-1:0] d1_ticks;

  assign hi_sum = HI_W'(hi11) + HI_W'(hi01) + HI_W'(hi10) + HI_W'(lo_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v <= 1'b0;
    end else if (en) begin
      d1_v <= lo_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_ticks <= hi_sum[TICK_LSB+TICKS_W-1:TICK_LSB];
    end
  end

  // prescaler stage: psc+1 = ceil(ticks / 2^COUNTER_BITS)
  logic [SUM_W-1:0]   span_c;
  logic [SUM_W-1:0]   sum_c;
  logic [SUM_W-1:0]   psc_full;
  logic [SUM_W-1:0]   psc_m1_full;
  logic               err_c;

  assign span_c      = SUM_W'(1) << COUNTER_BITS;
  assign sum_c       = {1'b0, d1_ticks} + span_c - SUM_W'(1);
  assign psc_full    = sum_c >> COUNTER_BITS;
  assign psc_m1_full = psc_full - SUM_W'(1);
  assign err_c       = (d1_ticks == '0) | (psc_full > span_c);

  logic               p_v;
  logic [TICKS_W-1:0] p_ticks;
  logic [PSC_W-1:0]   p_psc;
  logic [SIDE_W-1:0]  p_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (en) begin
      p_v <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ticks <= d1_ticks;
      p_psc   <= psc_full[PSC_W-1:0];
      p_side  <= {err_c, psc_m1_full[FIELD_W-1:0]};
    end
  end

  // reload+1 = ticks / (psc+1), bounded by 2^COUNTER_BITS when valid
  logic              d2_v;
  logic [PSC_W-1:0]  d2_arr;
  logic [SIDE_W-1:0] d2_side;

  tpr_pipe_div #(
    .DIVIDEND_W (TICKS_W),
    .DIVISOR_W  (PSC_W),
    .QUOT_W     (PSC_W),
    .SIDE_W     (SIDE_W)
  ) u_div_arr (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_v),
    .dividend  (p_ticks),
    .divisor   (p_psc),
    .side_in   (p_side),
    .out_valid (d2_v),
    .quotient  (d2_arr),
    .side_out  (d2_side)
  );

  logic [RW-1:0]      arr_m1;
  logic               r_err;
  logic [FIELD_W-1:0] r_pres;
  logic [FIELD_W-1:0] r_rel;

  assign arr_m1 = RW'(d2_arr) - RW'(1);
  assign r_err  = d2_side[FIELD_W];
  assign r_pres = r_err ? '0 : d2_side[FIELD_W-1:0];
  assign r_rel  = r_err ? '0 : arr_m1[FIELD_W-1:0];

  // output register plus one skid slot
  logic               take;
  logic [FIELD_W-1:0] o_pres, o_rel, sk_pres, sk_rel;
  logic               o_st, sk_st;

  assign take = m_tvalid & m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else if (skid_v) begin
      if (take) begin
        skid_v <= 1'b0;
      end
    end else if (d2_v) begin
      if (!m_tvalid || take) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end else if (take) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (take) begin
        o_pres <= sk_pres;
        o_rel  <= sk_rel;
        o_st   <= sk_st;
      end
    end else if (d2_v) begin
      if (!m_tvalid || take) begin
        o_pres <= r_pres;
        o_rel  <= r_rel;
        o_st   <= r_err;
      end else begin
        sk_pres <= r_pres;
        sk_rel  <= r_rel;
        sk_st   <= r_err;
      end
    end
  end

  assign m_tdata = {o_rel, o_pres};
  assign m_tuser = o_st;

endmodule
